FILE: src/asa_pkg.sv
package asa_pkg;

    localparam int ATLAS_WIDTH_DEF = 512;
    localparam int MAX_ATLASES_DEF = 16;
    localparam int MAX_SLOTS_DEF   = 64;

    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SLOT_LOG2 = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SLOT_LOG2 = 1'd1;

    localparam logic [CFG_W-1:0] MIN_LOG2_RST = 4'd8;
    localparam logic [CFG_W-1:0] MAX_LOG2_RST = 4'd8;
    localparam logic [CFG_W-1:0] LOG2_LO      = 4'd7;
    localparam logic [CFG_W-1:0] LOG2_HI      = 4'd9;

    localparam int EXT_W      = 12;
    localparam int ATLAS_W    = 4;
    localparam int SLOT_W     = 6;
    localparam int LG_W       = 4;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 10;
    localparam int OFS_W      = 9;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_KEPT     = 3'd0,
        ST_EXISTING = 3'd1,
        ST_NEW      = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HELD,
        S_CHECK,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_held;
        logic free_held;
        logic set_release;
        logic set_keep;
        logic scan_start;
        logic scan_step;
        logic grant;
        logic open_new;
        logic set_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic keep;
        logic hit;
        logic done;
        logic room;
        logic out_free;
    } t_stat;

endpackage

FILE: src/atlas_slot_allocator.sv
// Square-slot allocator over a growing set of texture atlases. Each input word either requests
// a slot for a surface (tuser action 0) or releases the slot it holds (action 1), and yields
// exactly one result word whose tuser carries the status: kept, slot in an existing atlas,
// new atlas opened, no atlas free, or released. Slot size is the surface extent rounded
// between 2^min_slot_log2 and 2^max_slot_log2 (both taken as 7..9), and may end up half the
// minimum. Atlas state lives in one single-port table read through a registered port, and a
// request scans the open atlases in that table one atlas per cycle. A new word may be
// accepted while the previous result still waits on the output. The min/max registers may
// only be written while no word is in flight.
module atlas_slot_allocator #(
    parameter int ATLAS_WIDTH = asa_pkg::ATLAS_WIDTH_DEF,
    parameter int MAX_ATLASES = asa_pkg::MAX_ATLASES_DEF,
    parameter int MAX_SLOTS   = asa_pkg::MAX_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [asa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [asa_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // surface_extent, held_valid, held_atlas, held_slot, zero pad
    input  logic [asa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // atlas_index, slot_index, slot_size, x_offset, y_offset, zero pad
    output logic [asa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [asa_pkg::STATUS_W-1:0]   m_axis_tuser
);

    asa_pkg::t_cmd  cmd;
    asa_pkg::t_stat stat;

    logic [asa_pkg::ATLAS_W-1:0] atlas_index;
    logic [asa_pkg::SLOT_W-1:0]  slot_index;
    logic [asa_pkg::SIZE_W-1:0]  slot_size;
    logic [asa_pkg::OFS_W-1:0]   x_offset;
    logic [asa_pkg::OFS_W-1:0]   y_offset;

    asa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    asa_datapath #(
        .ATLAS_WIDTH (ATLAS_WIDTH),
        .MAX_ATLASES (MAX_ATLASES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (s_axis_tuser),
        .i_extent      (s_axis_tdata[11:0]),
        .i_held_valid  (s_axis_tdata[12]),
        .i_held_atlas  (s_axis_tdata[16:13]),
        .i_held_slot   (s_axis_tdata[22:17]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_atlas_index (atlas_index),
        .o_slot_index  (slot_index),
        .o_slot_size   (slot_size),
        .o_x_offset    (x_offset),
        .o_y_offset    (y_offset)
    );

    assign m_axis_tdata = {2'b00, y_offset, x_offset, slot_size, slot_index, atlas_index};

endmodule

FILE: src/asa_ctrl.sv
module asa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  asa_pkg::t_stat i_stat,
    output asa_pkg::t_cmd  o_cmd
);

    asa_pkg::t_state r_state;
    asa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            asa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = asa_pkg::S_HELD;
                end
            end
            asa_pkg::S_HELD: begin
                o_cmd.rd_held = 1'b1;
                n_state       = asa_pkg::S_CHECK;
            end
            asa_pkg::S_CHECK: begin
                if (i_stat.is_release) begin
                    o_cmd.free_held   = 1'b1;
                    o_cmd.set_release = 1'b1;
                    n_state           = asa_pkg::S_OUT;
                end else if (i_stat.keep) begin
                    o_cmd.set_keep = 1'b1;
                    n_state        = asa_pkg::S_OUT;
                end else begin
                    o_cmd.free_held  = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = asa_pkg::S_SCAN;
                end
            end
            asa_pkg::S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.grant = 1'b1;
                    n_state     = asa_pkg::S_OUT;
                end else if (i_stat.done) begin
                    if (i_stat.room) begin
                        o_cmd.open_new = 1'b1;
                    end else begin
                        o_cmd.set_full = 1'b1;
                    end
                    n_state = asa_pkg::S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            asa_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = asa_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: src/asa_datapath.sv
module asa_datapath #(
    parameter int ATLAS_WIDTH = asa_pkg::ATLAS_WIDTH_DEF,
    parameter int MAX_ATLASES = asa_pkg::MAX_ATLASES_DEF,
    parameter int MAX_SLOTS   = asa_pkg::MAX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  asa_pkg::t_cmd                 i_cmd,
    output asa_pkg::t_stat                o_stat,
    input  logic                          i_cfg_we,
    input  logic [asa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [asa_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_action,
    input  logic [asa_pkg::EXT_W-1:0]     i_extent,
    input  logic                          i_held_valid,
    input  logic [asa_pkg::ATLAS_W-1:0]   i_held_atlas,
    input  logic [asa_pkg::SLOT_W-1:0]    i_held_slot,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [asa_pkg::STATUS_W-1:0]  o_status,
    output logic [asa_pkg::ATLAS_W-1:0]   o_atlas_index,
    output logic [asa_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [asa_pkg::SIZE_W-1:0]    o_slot_size,
    output logic [asa_pkg::OFS_W-1:0]     o_x_offset,
    output logic [asa_pkg::OFS_W-1:0]     o_y_offset
);

    localparam int IW      = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
    localparam int CW      = $clog2(MAX_ATLASES + 1);
    localparam int SW      = $clog2(MAX_SLOTS);
    localparam int FW      = $clog2(MAX_SLOTS + 1);
    localparam int AW_LOG2 = $clog2(ATLAS_WIDTH);
    localparam int LW      = asa_pkg::LG_W;
    localparam int AIW     = asa_pkg::ATLAS_W;
    localparam int SIW     = asa_pkg::SLOT_W;

    function automatic logic [LW-1:0] f_clamp(input logic [LW-1:0] v);
        logic [LW-1:0] r;
        r = v;
        if (v < asa_pkg::LOG2_LO) r = asa_pkg::LOG2_LO;
        if (v > asa_pkg::LOG2_HI) r = asa_pkg::LOG2_HI;
        return r;
    endfunction

    // double toward the maximum, then halve while too large
    function automatic logic [LW-1:0] f_round(input logic [asa_pkg::EXT_W-1:0] ext,
                                              input logic [LW-1:0] mn,
                                              input logic [LW-1:0] mx);
        logic [LW-1:0] lg;
        logic [asa_pkg::EXT_W:0] ext_w;
        lg    = mn;
        ext_w = {1'b0, ext};
        for (int k = 0; k < 3; k++) begin
            if (((13'd1 << lg) < ext_w) && (lg < mx)) lg = lg + 4'd1;
        end
        for (int k = 0; k < 4; k++) begin
            if ((lg >= mn) && (((13'd1 << lg) > ext_w) || (lg > mx))) lg = lg - 4'd1;
        end
        return lg;
    endfunction

    function automatic logic [FW-1:0] f_slots(input logic [LW-1:0] lg);
        int d;
        int n;
        d = ATLAS_WIDTH >> lg;
        n = d * d;
        if (n < 1) n = 1;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return FW'(n);
    endfunction

    function automatic logic [LW-1:0] f_row_log2(input logic [LW-1:0] lg);
        logic [LW-1:0] r;
        r = '0;
        if (AW_LOG2 > int'(lg)) r = LW'(AW_LOG2 - int'(lg));
        return r;
    endfunction

    logic [LW-1:0]  r_min_lg;
    logic [LW-1:0]  r_max_lg;
    logic           r_action;
    logic           r_hv;
    logic [AIW-1:0] r_ha;
    logic [SIW-1:0] r_hs;
    logic [LW-1:0]  r_lg;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic [IW-1:0]  r_rd_idx;
    logic           r_rd_vld;

    logic [LW-1:0]        mem_size [MAX_ATLASES];
    logic [FW-1:0]        mem_free [MAX_ATLASES];
    logic [MAX_SLOTS-1:0] mem_occ  [MAX_ATLASES];
    logic [LW-1:0]        r_rd_size;
    logic [FW-1:0]        r_rd_free;
    logic [MAX_SLOTS-1:0] r_rd_occ;

    asa_pkg::t_status r_st;
    logic [AIW-1:0]   r_ra;
    logic [SIW-1:0]   r_rs;

    logic                        r_o_valid;
    logic [asa_pkg::STATUS_W-1:0] r_o_st;
    logic [AIW-1:0]              r_o_a;
    logic [SIW-1:0]              r_o_s;
    logic [asa_pkg::SIZE_W-1:0]  r_o_size;
    logic [asa_pkg::OFS_W-1:0]   r_o_x;
    logic [asa_pkg::OFS_W-1:0]   r_o_y;

    logic [IW+AIW-1:0]    ha_wide;
    logic [IW-1:0]        ha_addr;
    logic                 held_open;
    logic [FW-1:0]        held_n;
    logic                 held_in;
    logic                 held_occ;
    logic [FW-1:0]        lg_n;
    logic [MAX_SLOTS-1:0] slot_mask;
    logic [MAX_SLOTS-1:0] freebits;
    logic [SW-1:0]        enc;
    logic [SW+SIW-1:0]    enc_wide;
    logic [IW+AIW-1:0]    rd_idx_wide;
    logic [IW+AIW-1:0]    cnt_idx_wide;
    logic                 rd_issue;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [LW-1:0]        wr_size;
    logic [FW-1:0]        wr_free;
    logic [MAX_SLOTS-1:0] wr_occ;
    logic                 place;
    logic [LW-1:0]        row_lg;
    logic [15:0]          row_mask;
    logic [15:0]          x_full;
    logic [15:0]          y_full;

    assign ha_wide   = {{IW{1'b0}}, r_ha};
    assign ha_addr   = ha_wide[IW-1:0];
    assign held_open = r_hv && ({{CW{1'b0}}, r_ha} < {{AIW{1'b0}}, r_count});
    assign held_n    = f_slots(r_rd_size);
    assign held_in   = {{FW{1'b0}}, r_hs} < {{SIW{1'b0}}, held_n};
    assign held_occ  = held_open && held_in && r_rd_occ[r_hs[SW-1:0]];
    assign lg_n      = f_slots(r_lg);

    always_comb begin
        for (int b = 0; b < MAX_SLOTS; b++) begin
            slot_mask[b] = (b < int'(lg_n));
        end
    end

    assign freebits = ~r_rd_occ & slot_mask;

    always_comb begin
        enc = '0;
        for (int b = MAX_SLOTS - 1; b >= 0; b--) begin
            if (freebits[b]) enc = SW'(b);
        end
    end

    assign enc_wide     = {{SIW{1'b0}}, enc};
    assign rd_idx_wide  = {{AIW{1'b0}}, r_rd_idx};
    assign cnt_idx_wide = {{AIW{1'b0}}, r_count[IW-1:0]};

    assign rd_issue = i_cmd.scan_step && (r_idx < r_count);
    assign rd_en    = i_cmd.rd_held || rd_issue;
    assign rd_addr  = i_cmd.rd_held ? ha_addr : r_idx[IW-1:0];

    assign o_stat.is_release = r_action;
    assign o_stat.keep       = held_open && (r_rd_size == r_lg);
    assign o_stat.hit        = r_rd_vld && (r_rd_size == r_lg) && (r_rd_free != '0)
                               && (|freebits);
    assign o_stat.done       = (r_idx >= r_count) && !r_rd_vld;
    assign o_stat.room       = r_count < CW'(MAX_ATLASES);
    assign o_stat.out_free   = !r_o_valid || i_out_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ha_addr;
        wr_size = r_rd_size;
        wr_free = r_rd_free;
        wr_occ  = r_rd_occ;
        if (i_cmd.free_held && held_occ) begin
            wr_en  = 1'b1;
            wr_occ = r_rd_occ & ~({{(MAX_SLOTS-1){1'b0}}, 1'b1} << r_hs[SW-1:0]);
            wr_free = r_rd_free + FW'(1);
        end else if (i_cmd.grant) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx;
            wr_occ  = r_rd_occ | ({{(MAX_SLOTS-1){1'b0}}, 1'b1} << enc);
            wr_free = r_rd_free - FW'(1);
        end else if (i_cmd.open_new) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
            wr_size = r_lg;
            wr_occ  = {{(MAX_SLOTS-1){1'b0}}, 1'b1};
            wr_free = lg_n - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_size[wr_addr] <= wr_size;
            mem_free[wr_addr] <= wr_free;
            mem_occ[wr_addr]  <= wr_occ;
        end
        if (rd_en) begin
            r_rd_size <= mem_size[rd_addr];
            r_rd_free <= mem_free[rd_addr];
            r_rd_occ  <= mem_occ[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_lg <= asa_pkg::MIN_LOG2_RST;
            r_max_lg <= asa_pkg::MAX_LOG2_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == asa_pkg::CFG_MIN_SLOT_LOG2) r_min_lg <= i_cfg_wdata;
            if (i_cfg_addr == asa_pkg::CFG_MAX_SLOT_LOG2) r_max_lg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_hv     <= i_held_valid;
            r_ha     <= i_held_atlas;
            r_hs     <= i_held_slot;
            r_lg     <= f_round(i_extent, f_clamp(r_min_lg), f_clamp(r_max_lg));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= rd_issue;
                if (rd_issue) r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.open_new) r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) r_rd_idx <= r_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_release) begin
            r_st <= asa_pkg::ST_RELEASED;
        end else if (i_cmd.set_keep) begin
            r_st <= asa_pkg::ST_KEPT;
            r_ra <= r_ha;
            r_rs <= r_hs;
        end else if (i_cmd.grant) begin
            r_st <= asa_pkg::ST_EXISTING;
            r_ra <= rd_idx_wide[AIW-1:0];
            r_rs <= enc_wide[SIW-1:0];
        end else if (i_cmd.open_new) begin
            r_st <= asa_pkg::ST_NEW;
            r_ra <= cnt_idx_wide[AIW-1:0];
            r_rs <= '0;
        end else if (i_cmd.set_full) begin
            r_st <= asa_pkg::ST_FULL;
        end
    end

    assign place    = (r_st == asa_pkg::ST_KEPT) || (r_st == asa_pkg::ST_EXISTING)
                      || (r_st == asa_pkg::ST_NEW);
    assign row_lg   = f_row_log2(r_lg);
    assign row_mask = (16'd1 << row_lg) - 16'd1;
    assign x_full   = ({10'd0, r_rs} & row_mask) << r_lg;
    assign y_full   = ({10'd0, r_rs} >> row_lg) << r_lg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_st   <= r_st;
            r_o_a    <= place ? r_ra : '0;
            r_o_s    <= place ? r_rs : '0;
            r_o_size <= (r_st == asa_pkg::ST_RELEASED) ? '0
                        : (asa_pkg::SIZE_W'(1) << r_lg);
            r_o_x    <= place ? x_full[asa_pkg::OFS_W-1:0] : '0;
            r_o_y    <= place ? y_full[asa_pkg::OFS_W-1:0] : '0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_st;
    assign o_atlas_index = r_o_a;
    assign o_slot_index  = r_o_s;
    assign o_slot_size   = r_o_size;
    assign o_x_offset    = r_o_x;
    assign o_y_offset    = r_o_y;

endmodule
